[rtl/irct_pkg.sv]
package irct_pkg;

	// Limits of the line format.
	localparam int PREFIX_SIZE  = 256;
	localparam int COMMAND_SIZE = 32;
	localparam int MAX_PARAMS   = 15;
	localparam int PARAM_KEEP   = 511;

	// The token length counter covers the longest kept prefix or parameter.
	localparam int LEN_W = 9;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_PREFIX  = 2'd1;
	localparam logic [1:0] KIND_COMMAND = 2'd2;
	localparam logic [1:0] KIND_PARAM   = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_PFX_UNTERM = 3'd1;
	localparam logic [2:0] ST_PFX_LONG   = 3'd2;
	localparam logic [2:0] ST_CMD_EMPTY  = 3'd3;
	localparam logic [2:0] ST_CMD_LONG   = 3'd4;

	typedef enum logic [7:0] {
		PH_START   = 8'b0000_0001,
		PH_PREFIX  = 8'b0000_0010,
		PH_CMDGAP  = 8'b0000_0100,
		PH_COMMAND = 8'b0000_1000,
		PH_PGAP    = 8'b0001_0000,
		PH_PARAM   = 8'b0010_0000,
		PH_TRAIL   = 8'b0100_0000,
		PH_DONE    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [1:0] field_kind;
		logic [3:0] param_index;
		logic       token_start;
		logic       is_trailing;
		logic       line_done;
		logic [2:0] status;
		logic [3:0] param_count;
	} result_t;

endpackage

[rtl/irct_core.sv]
module irct_core
	import irct_pkg::*;
#(
	parameter int PREFIX_SIZE  = irct_pkg::PREFIX_SIZE,
	parameter int COMMAND_SIZE = irct_pkg::COMMAND_SIZE,
	parameter int MAX_PARAMS   = irct_pkg::MAX_PARAMS,
	parameter int PARAM_KEEP   = irct_pkg::PARAM_KEEP
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       line_end,
	output result_t    result
);

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [3:0]       count_q, count_d;
	logic [2:0]       err_q, err_d;

	// Error code left when a line stops in the given phase.
	function automatic logic [2:0] finish_err(phase_t ph, logic [2:0] err);
		logic [2:0] e;
		e = err;
		if (ph == PH_START || ph == PH_CMDGAP) begin
			e = ST_CMD_EMPTY;
		end else if (ph == PH_PREFIX) begin
			e = ST_PFX_UNTERM;
		end
		return e;
	endfunction

	always_comb begin
		logic eol;
		logic sp;
		logic [1:0] kind;
		logic [3:0] pidx;
		logic start;
		logic trail;
		logic [2:0] status;

		eol     = (data_byte == CH_CR) || (data_byte == CH_LF);
		sp      = (data_byte == CH_SPACE);
		phase_d = phase_q;
		len_d   = len_q;
		count_d = count_q;
		err_d   = err_q;
		kind    = KIND_NONE;
		pidx    = 4'd0;
		start   = 1'b0;
		trail   = 1'b0;
		status  = ST_OK;

		if (data_byte == CH_NUL) begin
			// A zero byte ends the string; the rest of the line is ignored.
			if (phase_q != PH_DONE) begin
				err_d   = finish_err(phase_q, err_q);
				phase_d = PH_DONE;
			end
		end else begin
			unique case (phase_q)
				PH_START, PH_CMDGAP: begin
					if (phase_q == PH_START && data_byte == CH_COLON) begin
						phase_d = PH_PREFIX;
						len_d   = '0;
					end else if (sp) begin
						phase_d = PH_CMDGAP;
					end else if (eol) begin
						err_d   = ST_CMD_EMPTY;
						phase_d = PH_DONE;
					end else begin
						// First command byte.
						phase_d = PH_COMMAND;
						kind    = KIND_COMMAND;
						start   = 1'b1;
						len_d   = LEN_W'(1);
					end
				end
				PH_PREFIX: begin
					if (sp) begin
						phase_d = (err_q == ST_PFX_LONG) ? PH_DONE : PH_CMDGAP;
					end else if (len_q >= LEN_W'(PREFIX_SIZE - 1)) begin
						err_d = ST_PFX_LONG;
					end else begin
						kind  = KIND_PREFIX;
						start = (len_q == '0);
						len_d = len_q + LEN_W'(1);
					end
				end
				PH_COMMAND: begin
					if (sp || eol) begin
						phase_d = (err_q != ST_OK || eol) ? PH_DONE : PH_PGAP;
					end else if (len_q >= LEN_W'(COMMAND_SIZE - 1)) begin
						err_d = ST_CMD_LONG;
					end else begin
						kind  = KIND_COMMAND;
						start = (len_q == '0);
						len_d = len_q + LEN_W'(1);
					end
				end
				PH_PGAP: begin
					if (eol || count_q >= 4'(MAX_PARAMS)) begin
						phase_d = PH_DONE;
					end else if (!sp) begin
						count_d = count_q + 4'd1;
						len_d   = '0;
						if (data_byte == CH_COLON) begin
							phase_d = PH_TRAIL;
						end else begin
							phase_d = PH_PARAM;
							kind    = KIND_PARAM;
							start   = 1'b1;
							len_d   = LEN_W'(1);
							pidx    = count_q;
						end
					end
				end
				PH_PARAM, PH_TRAIL: begin
					if (eol) begin
						phase_d = PH_DONE;
					end else if (phase_q == PH_PARAM && sp) begin
						phase_d = (count_q >= 4'(MAX_PARAMS)) ? PH_DONE : PH_PGAP;
					end else if (len_q < LEN_W'(PARAM_KEEP)) begin
						kind  = KIND_PARAM;
						start = (len_q == '0);
						len_d = len_q + LEN_W'(1);
						pidx  = count_q - 4'd1;
						trail = (phase_q == PH_TRAIL);
					end
				end
				default: begin
				end
			endcase
		end

		if (line_end) begin
			if (phase_d != PH_DONE) begin
				err_d = finish_err(phase_d, err_d);
			end
			status = err_d;
		end

		result.byte_out    = data_byte;
		result.field_kind  = kind;
		result.param_index = pidx;
		result.token_start = start;
		result.is_trailing = trail;
		result.line_done   = line_end;
		result.status      = status;
		result.param_count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			len_q   <= '0;
			count_q <= '0;
			err_q   <= ST_OK;
		end else if (step) begin
			if (line_end) begin
				phase_q <= PH_START;
				len_q   <= '0;
				count_q <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_d;
				len_q   <= len_d;
				count_q <= count_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

[rtl/irc_line_tokenizer.sv]
// Channel   Direction  Handshake                 Word
// byte      in         byte_valid / byte_ready   data_byte, line_end
// tag       out        tag_valid / tag_ready     byte_out, field_kind, param_index,
//                                                token_start, is_trailing, line_done,
//                                                status, param_count
//
// One word in, one tagged word out. An accepted word sits in the input register while the
// parser tags it, and its tag is loaded into the result register once that register is
// empty or being drained, and the tag is offered from there. A new word is taken every
// cycle while the output is not stalled; the parser's phase and counter update sets
// that rate. arst_n clears the valid bits and the parser state to the start of a line.
// A stalled output holds both registers; the input side stays open while the input
// register is empty.
module irc_line_tokenizer
	import irct_pkg::*;
#(
	parameter int PREFIX_SIZE  = irct_pkg::PREFIX_SIZE,
	parameter int COMMAND_SIZE = irct_pkg::COMMAND_SIZE,
	parameter int MAX_PARAMS   = irct_pkg::MAX_PARAMS,
	parameter int PARAM_KEEP   = irct_pkg::PARAM_KEEP
)
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       line_end,

	output logic       tag_valid,
	input  logic       tag_ready,
	output logic [7:0] byte_out,
	output logic [1:0] field_kind,
	output logic [3:0] param_index,
	output logic       token_start,
	output logic       is_trailing,
	output logic       line_done,
	output logic [2:0] status,
	output logic [3:0] param_count
);

	// Input register.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       end_s1;

	// Result register.
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_comb;

	logic adv_s2;
	logic take_s1;

	// The result register can load whenever it is empty or being drained.
	assign adv_s2     = !valid_s2 || tag_ready;
	assign byte_ready = !valid_s1 || adv_s2;
	assign take_s1    = byte_valid && byte_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			data_s1 <= data_byte;
			end_s1  <= line_end;
		end
	end

	// The parser advances its state only when its word moves into the result register.
	irct_core #(
		.PREFIX_SIZE  (PREFIX_SIZE),
		.COMMAND_SIZE (COMMAND_SIZE),
		.MAX_PARAMS   (MAX_PARAMS),
		.PARAM_KEEP   (PARAM_KEEP)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && adv_s2),
		.data_byte (data_s1),
		.line_end  (end_s1),
		.result    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign tag_valid   = valid_s2;
	assign byte_out    = res_s2.byte_out;
	assign field_kind  = res_s2.field_kind;
	assign param_index = res_s2.param_index;
	assign token_start = res_s2.token_start;
	assign is_trailing = res_s2.is_trailing;
	assign line_done   = res_s2.line_done;
	assign status      = res_s2.status;
	assign param_count = res_s2.param_count;

endmodule
